// ===== hw/rtl/acf_pkg.sv =====
// Shared constants and control word type for the frustum culling pipeline.
package acf_pkg;

    localparam int FRAC_BITS = 8;
    localparam int TAG_W     = 32;
    localparam int ROW_W     = 64;
    localparam int BOX_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_Z   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_W   = 3'd4;

    typedef struct packed {
        logic             vld;
        logic             cull;
        logic             vis;
        logic [TAG_W-1:0] tag;
    } t_ctl;

endpackage

// ===== hw/rtl/acf_xform_cell.sv =====
// Transform cell: adds one local axis into world center and extents of all three rows.
module acf_xform_cell #(
    parameter int W    = 16,
    parameter int AXIS = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  acf_pkg::t_ctl       i_ctl,
    input  logic signed [W-1:0] i_l  [3][3],
    input  logic signed [W:0]   i_c2 [3],
    input  logic signed [W:0]   i_e2 [3],
    input  logic signed [2*W+2:0] i_wc [3],
    input  logic signed [2*W+2:0] i_we [3],
    output acf_pkg::t_ctl       o_ctl,
    output logic signed [W-1:0] o_l  [3][3],
    output logic signed [W:0]   o_c2 [3],
    output logic signed [W:0]   o_e2 [3],
    output logic signed [2*W+2:0] o_wc [3],
    output logic signed [2*W+2:0] o_we [3]
);

    localparam int WC = 2*W+3;

    acf_pkg::t_ctl         r_ctl;
    logic signed [W-1:0]   r_l  [3][3];
    logic signed [W:0]     r_c2 [3];
    logic signed [W:0]     r_e2 [3];
    logic signed [WC-1:0]  r_wc [3];
    logic signed [WC-1:0]  r_we [3];
    logic signed [WC-1:0]  n_wc [3];
    logic signed [WC-1:0]  n_we [3];
    logic signed [W:0]     labs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            labs[i] = i_l[i][AXIS][W-1] ? -(W+1)'(i_l[i][AXIS]) : (W+1)'(i_l[i][AXIS]);
            n_wc[i] = i_wc[i] + WC'(i_c2[AXIS] * i_l[i][AXIS]);
            n_we[i] = i_we[i] + WC'(i_e2[AXIS] * labs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_l  <= i_l;
            r_c2 <= i_c2;
            r_e2 <= i_e2;
            r_wc <= n_wc;
            r_we <= n_we;
        end
    end

    assign o_ctl = r_ctl;
    assign o_l   = r_l;
    assign o_c2  = r_c2;
    assign o_e2  = r_e2;
    assign o_wc  = r_wc;
    assign o_we  = r_we;

endmodule

// ===== hw/rtl/acf_plane_cell.sv =====
// Plane cell: adds one axis term of one plane; axis 0 closes the previous plane.
module acf_plane_cell #(
    parameter int W    = 16,
    parameter int AXIS = 0,
    parameter bit CHK  = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  acf_pkg::t_ctl         i_ctl,
    input  logic signed [2*W+2:0] i_wc [3],
    input  logic signed [2*W+2:0] i_we [3],
    input  logic signed [3*W+6:0] i_acc,
    input  logic                  i_prev_nz,
    input  logic signed [W:0]     i_n,
    input  logic signed [3*W+6:0] i_base,
    output acf_pkg::t_ctl         o_ctl,
    output logic signed [2*W+2:0] o_wc [3],
    output logic signed [2*W+2:0] o_we [3],
    output logic signed [3*W+6:0] o_acc
);

    localparam int WC = 2*W+3;
    localparam int AW = 3*W+7;

    acf_pkg::t_ctl        r_ctl;
    acf_pkg::t_ctl        n_ctl;
    logic signed [WC-1:0] r_wc [3];
    logic signed [WC-1:0] r_we [3];
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [AW-1:0] base;
    logic signed [W+1:0]  nabs;

    always_comb begin
        n_ctl = i_ctl;
        if (AXIS == 0) begin
            base = i_base;
            if (CHK && i_ctl.cull && !i_prev_nz && i_acc[AW-1]) begin
                n_ctl.vis = 1'b0;
            end
        end else begin
            base = i_acc;
        end
        // one extra bit so the most negative normal entry has a magnitude
        nabs  = i_n[W] ? -(W+2)'(i_n) : (W+2)'(i_n);
        n_acc = base + AW'(i_wc[AXIS] * i_n) + AW'(i_we[AXIS] * nabs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
        if (i_en) begin
            r_wc  <= i_wc;
            r_we  <= i_we;
            r_acc <= n_acc;
        end
    end

    assign o_ctl = r_ctl;
    assign o_wc  = r_wc;
    assign o_we  = r_we;
    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/aabb_frustum_cull.sv =====
// Top level: view-frustum culling of axis-aligned boxes, one instance per word.
//
// Input stream s_axis carries one mesh instance per word: three model rows,
// the local box corners and a tag in tdata, box-valid and mesh-present in
// tuser. Output stream m_axis returns one word per instance in order: the tag
// in tdata, the visible flag in tuser[0].
// The pipeline is an input register, three transform cells (one per local
// axis), eighteen plane cells (six planes times three axes) and an output
// register. One word is taken every cycle while the output side keeps up.
// The whole chain advances together; when m_axis holds a word the receiver
// has not taken, every stage holds and s_axis_tready drops in that cycle.
// Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_data) take effect at the next
// edge. The user must make them while the pipeline is empty; nothing enforces it.
// Synchronous reset clears configuration and control registers, disables
// culling and empties the pipeline; no word is lost or repeated across a stall.
module aabb_frustum_cull #(
    parameter int COORD_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // model_row_x, model_row_y, model_row_z, box_min, box_max, instance_tag
    input  logic [319:0] s_axis_tdata,
    // box_valid, mesh_present
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tag_out
    output logic [31:0]  m_axis_tdata,
    // visible
    output logic         m_axis_tuser
);

    localparam int W  = COORD_WIDTH;
    localparam int WC = 2*W+3;
    localparam int AW = 3*W+7;
    localparam int PW = 4*W+64;
    localparam int FB = acf_pkg::FRAC_BITS;
    localparam int NC = 18;

    logic        r_enable;
    logic [63:0] r_vp [4];

    logic en;

    // plane normals from the view-projection rows
    logic signed [W-1:0] vpe [4][4];
    logic signed [W:0]   pn  [6][4];
    logic                pnz [6];
    logic signed [AW-1:0] pbase [6];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                vpe[r][k] = W'({{(PW-64){1'b0}}, r_vp[r]} >> (k*W));
            end
        end
        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 4; k++) begin
                if (p % 2 == 1) begin
                    pn[p][k] = (W+1)'(vpe[3][k]) - (W+1)'(vpe[p/2][k]);
                end else begin
                    pn[p][k] = (W+1)'(vpe[3][k]) + (W+1)'(vpe[p/2][k]);
                end
            end
            pnz[p]   = (pn[p][0] == '0) && (pn[p][1] == '0) && (pn[p][2] == '0);
            pbase[p] = AW'(pn[p][3]) <<< (2*FB+1);
        end
    end

    // input decode
    logic [63:0]         in_row [3];
    logic signed [W-1:0] in_l   [3][3];
    logic signed [W-1:0] in_t   [3];
    logic signed [W-1:0] bmin   [3];
    logic signed [W-1:0] bmax   [3];
    logic signed [W:0]   in_c2  [3];
    logic signed [W:0]   in_e2  [3];
    logic signed [WC-1:0] in_wc [3];
    logic signed [WC-1:0] in_we [3];
    acf_pkg::t_ctl       in_ctl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_row[i] = s_axis_tdata[64*i +: 64];
            for (int k = 0; k < 3; k++) begin
                in_l[i][k] = W'({{(PW-64){1'b0}}, in_row[i]} >> (k*W));
            end
            in_t[i] = W'({{(PW-64){1'b0}}, in_row[i]} >> (3*W));
            bmin[i] = W'({{(PW-48){1'b0}}, s_axis_tdata[239:192]} >> (i*W));
            bmax[i] = W'({{(PW-48){1'b0}}, s_axis_tdata[287:240]} >> (i*W));
            if (s_axis_tuser[0]) begin
                in_c2[i] = (W+1)'(bmax[i]) + (W+1)'(bmin[i]);
                in_e2[i] = (W+1)'(bmax[i]) - (W+1)'(bmin[i]);
            end else begin
                in_c2[i] = '0;
                in_e2[i] = (W+1)'(1 << FB);
            end
            in_wc[i] = WC'(in_t[i]) <<< (FB+1);
            in_we[i] = '0;
        end
        in_ctl.vld  = s_axis_tvalid;
        in_ctl.cull = r_enable & s_axis_tuser[1];
        in_ctl.vis  = ~r_enable | s_axis_tuser[1];
        in_ctl.tag  = s_axis_tdata[319:288];
    end

    acf_pkg::t_ctl        r_ctl0;
    logic signed [W-1:0]  r_l0  [3][3];
    logic signed [W:0]    r_c20 [3];
    logic signed [W:0]    r_e20 [3];
    logic signed [WC-1:0] r_wc0 [3];
    logic signed [WC-1:0] r_we0 [3];

    logic        r_ovld;
    logic        r_ovis;
    logic [31:0] r_otag;

    assign en            = ~r_ovld | m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            for (int r = 0; r < 4; r++) begin
                r_vp[r] <= '0;
            end
            r_ctl0 <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    acf_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                    acf_pkg::CFG_VP_X:   r_vp[0]  <= i_cfg_data;
                    acf_pkg::CFG_VP_Y:   r_vp[1]  <= i_cfg_data;
                    acf_pkg::CFG_VP_Z:   r_vp[2]  <= i_cfg_data;
                    acf_pkg::CFG_VP_W:   r_vp[3]  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (en) begin
                r_ctl0 <= in_ctl;
            end
        end
        if (en) begin
            r_l0  <= in_l;
            r_c20 <= in_c2;
            r_e20 <= in_e2;
            r_wc0 <= in_wc;
            r_we0 <= in_we;
        end
    end

    // transform chain
    acf_pkg::t_ctl        x_ctl [4];
    logic signed [W-1:0]  x_l   [4][3][3];
    logic signed [W:0]    x_c2  [4][3];
    logic signed [W:0]    x_e2  [4][3];
    logic signed [WC-1:0] x_wc  [4][3];
    logic signed [WC-1:0] x_we  [4][3];

    assign x_ctl[0] = r_ctl0;
    assign x_l[0]   = r_l0;
    assign x_c2[0]  = r_c20;
    assign x_e2[0]  = r_e20;
    assign x_wc[0]  = r_wc0;
    assign x_we[0]  = r_we0;

    for (genvar j = 0; j < 3; j++) begin : g_xf
        acf_xform_cell #(.W(W), .AXIS(j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (x_ctl[j]),
            .i_l     (x_l[j]),
            .i_c2    (x_c2[j]),
            .i_e2    (x_e2[j]),
            .i_wc    (x_wc[j]),
            .i_we    (x_we[j]),
            .o_ctl   (x_ctl[j+1]),
            .o_l     (x_l[j+1]),
            .o_c2    (x_c2[j+1]),
            .o_e2    (x_e2[j+1]),
            .o_wc    (x_wc[j+1]),
            .o_we    (x_we[j+1])
        );
    end

    // plane chain
    acf_pkg::t_ctl        p_ctl [NC+1];
    logic signed [WC-1:0] p_wc  [NC+1][3];
    logic signed [WC-1:0] p_we  [NC+1][3];
    logic signed [AW-1:0] p_acc [NC+1];

    assign p_ctl[0] = x_ctl[3];
    assign p_wc[0]  = x_wc[3];
    assign p_we[0]  = x_we[3];
    assign p_acc[0] = '0;

    for (genvar c = 0; c < NC; c++) begin : g_pl
        acf_plane_cell #(.W(W), .AXIS(c % 3), .CHK(c >= 3)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_ctl     (p_ctl[c]),
            .i_wc      (p_wc[c]),
            .i_we      (p_we[c]),
            .i_acc     (p_acc[c]),
            .i_prev_nz (pnz[(c >= 3) ? (c/3 - 1) : 0]),
            .i_n       (pn[c/3][c%3]),
            .i_base    (pbase[c/3]),
            .o_ctl     (p_ctl[c+1]),
            .o_wc      (p_wc[c+1]),
            .o_we      (p_we[c+1]),
            .o_acc     (p_acc[c+1])
        );
    end

    // output register, closes the last plane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= p_ctl[NC].vld;
        end
        if (en) begin
            r_ovis <= p_ctl[NC].vis
                      & ~(p_ctl[NC].cull & ~pnz[5] & p_acc[NC][AW-1]);
            r_otag <= p_ctl[NC].tag;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_otag;
    assign m_axis_tuser  = r_ovis;

`ifndef NO_ASSERTIONS
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");
    a_disabled_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_enable && !$past(r_enable) && m_axis_tvalid)
        |-> (m_axis_tuser || $past(r_enable, 23)))
        else $error("invisible word with culling disabled");
`endif

endmodule
